@@ rtl/avr109_pkg.sv @@
package avr109_pkg;

  localparam int MAX_RESULTS = 7;
  localparam int CNT_W       = 3;

  typedef enum logic [3:0] {
    PH_IDLE,
    PH_ADDR_HI,
    PH_ADDR_LO,
    PH_DEVTYPE,
    PH_LEN_HI,
    PH_LEN_LO,
    PH_TYPE,
    PH_LOAD,
    PH_READ_WAIT
  } phase_t;

  typedef enum logic [2:0] {
    K_TX,
    K_FILL,
    K_COMMIT,
    K_EEWR,
    K_FLRD,
    K_EERD,
    K_ERASE,
    K_END
  } kind_t;

  typedef enum logic [1:0] {
    MEM_UNKNOWN,
    MEM_FLASH,
    MEM_EEPROM
  } mem_t;

  typedef enum logic [1:0] {
    REQ_SERIAL,
    REQ_MEM_DATA,
    REQ_TIMEOUT,
    REQ_NONE
  } req_t;

  typedef enum logic [1:0] {
    CFG_SW_ID,
    CFG_VER_MAJOR,
    CFG_VER_MINOR
  } cfg_idx_t;

  // command letters
  localparam logic [7:0] CMD_ENTER_PROG  = 8'h50; // 'P'
  localparam logic [7:0] CMD_LEAVE_PROG  = 8'h4C; // 'L'
  localparam logic [7:0] CMD_AUTO_INC    = 8'h61; // 'a'
  localparam logic [7:0] CMD_LOAD_ADDR   = 8'h41; // 'A'
  localparam logic [7:0] CMD_ERASE_ALL   = 8'h65; // 'e'
  localparam logic [7:0] CMD_SEL_DEVICE  = 8'h54; // 'T'
  localparam logic [7:0] CMD_SIGNATURE   = 8'h73; // 's'
  localparam logic [7:0] CMD_DEV_CODES   = 8'h74; // 't'
  localparam logic [7:0] CMD_SW_ID       = 8'h53; // 'S'
  localparam logic [7:0] CMD_SW_VERSION  = 8'h56; // 'V'
  localparam logic [7:0] CMD_HW_VERSION  = 8'h76; // 'v'
  localparam logic [7:0] CMD_PROG_TYPE   = 8'h70; // 'p'
  localparam logic [7:0] CMD_BLOCK_SUPP  = 8'h62; // 'b'
  localparam logic [7:0] CMD_EXIT        = 8'h45; // 'E'
  localparam logic [7:0] CMD_BLOCK_LOAD  = 8'h42; // 'B'
  localparam logic [7:0] CMD_BLOCK_READ  = 8'h67; // 'g'

  // reply bytes and block type letters
  localparam logic [7:0] RSP_CR          = 8'h0D;
  localparam logic [7:0] RSP_YES         = 8'h59; // 'Y'
  localparam logic [7:0] RSP_UNKNOWN     = 8'h3F; // '?'
  localparam logic [7:0] RSP_HW_MAJOR    = 8'h31; // '1'
  localparam logic [7:0] RSP_HW_MINOR    = 8'h30; // '0'
  localparam logic [7:0] RSP_SERIAL_PROG = 8'h53; // 'S'
  localparam logic [7:0] RSP_DEV_CODE    = 8'h00;
  localparam logic [7:0] SIG_BYTE0       = 8'h01;
  localparam logic [7:0] SIG_BYTE1       = 8'hA7;
  localparam logic [7:0] SIG_BYTE2       = 8'h1E;
  localparam logic [7:0] TYPE_FLASH      = 8'h46; // 'F'
  localparam logic [7:0] TYPE_EEPROM     = 8'h45; // 'E'

  typedef struct packed {
    kind_t       kind;
    logic [7:0]  data;
    logic [23:0] addr;
  } result_t;

  typedef struct packed {
    logic [CNT_W-1:0]              count;
    result_t [MAX_RESULTS-1:0]     item;
  } res_list_t;

  function automatic result_t mk_result(kind_t k, logic [7:0] d, logic [23:0] a);
    result_t r;
    r.kind = k;
    r.data = d;
    r.addr = a;
    return r;
  endfunction

endpackage

@@ rtl/avr109_result_queue.sv @@
module avr109_result_queue (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  load,
  input  avr109_pkg::res_list_t list,
  input  logic                  take,
  output avr109_pkg::result_t   head,
  output logic                  valid,
  output logic                  last,
  output logic                  free
);
  import avr109_pkg::*;

  result_t [MAX_RESULTS-1:0] items;
  logic [CNT_W-1:0]          cnt;

  assign head  = items[0];
  assign valid = (cnt != '0);
  assign last  = (cnt == CNT_W'(1));
  // a new list may land in the same cycle the final pending item leaves
  assign free  = (cnt == '0) || (last && take);

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else if (load) begin
      cnt <= list.count;
    end else if (valid && take) begin
      cnt <= cnt - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      items <= list.item;
    end else if (valid && take) begin
      for (int i = 0; i < MAX_RESULTS - 1; i++) begin
        items[i] <= items[i+1];
      end
    end
  end

endmodule

@@ rtl/avr109_cmd_decode.sv @@
module avr109_cmd_decode #(
  parameter int PAGE_BYTES = 256,
  parameter int ADDR_BITS  = 24
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  accept,
  input  logic [1:0]            req_type,
  input  logic [7:0]            in_byte,
  input  logic [55:0]           sw_id,
  input  logic [7:0]            ver_major,
  input  logic [7:0]            ver_minor,
  output avr109_pkg::res_list_t results,
  output logic                  busy
);
  import avr109_pkg::*;

  localparam int          OFF_W   = $clog2(PAGE_BYTES);
  localparam logic [15:0] PAGE16  = 16'(PAGE_BYTES);
  localparam logic [63:0] RECIP_L = ((64'd1 << 32) + 64'(PAGE_BYTES) - 64'd1) / 64'(PAGE_BYTES);
  localparam logic [31:0] RECIP   = RECIP_L[31:0];

  typedef enum logic [2:0] {
    AOP_NONE,
    AOP_SET_HI,
    AOP_SET_LO,
    AOP_INC1,
    AOP_INC_PAGE
  } addr_op_t;

  phase_t                 phase, phase_next;
  logic [7:0]             cur_cmd, cur_cmd_next;
  logic [ADDR_BITS-1:0]   byte_address;
  logic [15:0]            block_length, block_length_next;
  logic [15:0]            bytes_remaining, bytes_remaining_next;
  mem_t                   mem_kind, mem_kind_next;
  logic                   session_over, session_over_next;
  logic [ADDR_BITS-1:0]   page_index;
  logic [OFF_W-1:0]       page_offset;
  logic                   fix_q, fix_r;
  addr_op_t               aop;

  logic [15:0]            rem_dec;
  logic [15:0]            idx;
  mem_t                   mtype;
  logic [CNT_W-1:0]       p;
  logic [23:0]            addr24;
  logic [23:0]            page24;

  logic [47:0]            quot_prod;
  logic [31:0]            back_prod;
  logic [15:0]            rem_val;
  logic [ADDR_BITS:0]     sum_pg;
  logic [OFF_W:0]         off_inc;

  assign busy    = fix_q || fix_r;
  assign rem_dec = bytes_remaining - 16'd1;
  assign idx     = block_length - bytes_remaining;
  assign addr24  = 24'(byte_address);
  assign page24  = 24'(page_index);

  always_comb begin
    priority if (in_byte == TYPE_FLASH) begin
      mtype = MEM_FLASH;
    end else if (in_byte == TYPE_EEPROM) begin
      mtype = MEM_EEPROM;
    end else begin
      mtype = MEM_UNKNOWN;
    end
  end

  always_comb begin
    phase_next           = phase;
    cur_cmd_next         = cur_cmd;
    block_length_next    = block_length;
    bytes_remaining_next = bytes_remaining;
    mem_kind_next        = mem_kind;
    session_over_next    = session_over;
    aop                  = AOP_NONE;
    results              = '0;
    p                    = '0;

    if (!session_over) begin
      unique case (req_t'(req_type))
        REQ_SERIAL: begin
          unique case (phase)
            PH_IDLE: begin
              cur_cmd_next = in_byte;
              unique case (in_byte)
                CMD_ENTER_PROG, CMD_LEAVE_PROG: begin
                  results.item[0] = mk_result(K_TX, RSP_CR, '0);
                  results.count   = CNT_W'(1);
                end
                CMD_AUTO_INC: begin
                  results.item[0] = mk_result(K_TX, RSP_YES, '0);
                  results.count   = CNT_W'(1);
                end
                CMD_LOAD_ADDR: phase_next = PH_ADDR_HI;
                CMD_ERASE_ALL: begin
                  results.item[0] = mk_result(K_ERASE, '0, '0);
                  results.item[1] = mk_result(K_TX, RSP_CR, '0);
                  results.count   = CNT_W'(2);
                end
                CMD_SEL_DEVICE: phase_next = PH_DEVTYPE;
                CMD_SIGNATURE: begin
                  results.item[0] = mk_result(K_TX, SIG_BYTE0, '0);
                  results.item[1] = mk_result(K_TX, SIG_BYTE1, '0);
                  results.item[2] = mk_result(K_TX, SIG_BYTE2, '0);
                  results.count   = CNT_W'(3);
                end
                CMD_DEV_CODES: begin
                  results.item[0] = mk_result(K_TX, RSP_DEV_CODE, '0);
                  results.count   = CNT_W'(1);
                end
                CMD_SW_ID: begin
                  for (int i = 0; i < 7; i++) begin
                    results.item[i] = mk_result(K_TX, sw_id[55-8*i -: 8], '0);
                  end
                  results.count = CNT_W'(7);
                end
                CMD_SW_VERSION: begin
                  results.item[0] = mk_result(K_TX, ver_major, '0);
                  results.item[1] = mk_result(K_TX, ver_minor, '0);
                  results.count   = CNT_W'(2);
                end
                CMD_HW_VERSION: begin
                  results.item[0] = mk_result(K_TX, RSP_HW_MAJOR, '0);
                  results.item[1] = mk_result(K_TX, RSP_HW_MINOR, '0);
                  results.count   = CNT_W'(2);
                end
                CMD_PROG_TYPE: begin
                  results.item[0] = mk_result(K_TX, RSP_SERIAL_PROG, '0);
                  results.count   = CNT_W'(1);
                end
                CMD_BLOCK_SUPP: begin
                  results.item[0] = mk_result(K_TX, RSP_YES, '0);
                  results.item[1] = mk_result(K_TX, PAGE16[15:8], '0);
                  results.item[2] = mk_result(K_TX, PAGE16[7:0], '0);
                  results.count   = CNT_W'(3);
                end
                CMD_EXIT: begin
                  results.item[0]   = mk_result(K_TX, RSP_CR, '0);
                  results.item[1]   = mk_result(K_END, '0, '0);
                  results.count     = CNT_W'(2);
                  session_over_next = 1'b1;
                end
                CMD_BLOCK_LOAD, CMD_BLOCK_READ: phase_next = PH_LEN_HI;
                default: begin
                  results.item[0] = mk_result(K_TX, RSP_UNKNOWN, '0);
                  results.count   = CNT_W'(1);
                end
              endcase
            end
            PH_ADDR_HI: begin
              aop        = AOP_SET_HI;
              phase_next = PH_ADDR_LO;
            end
            PH_ADDR_LO: begin
              aop             = AOP_SET_LO;
              results.item[0] = mk_result(K_TX, RSP_CR, '0);
              results.count   = CNT_W'(1);
              phase_next      = PH_IDLE;
            end
            PH_DEVTYPE: begin
              results.item[0] = mk_result(K_TX, RSP_CR, '0);
              results.count   = CNT_W'(1);
              phase_next      = PH_IDLE;
            end
            PH_LEN_HI: begin
              block_length_next = {in_byte, 8'h00};
              phase_next        = PH_LEN_LO;
            end
            PH_LEN_LO: begin
              block_length_next    = {block_length[15:8], in_byte};
              bytes_remaining_next = {block_length[15:8], in_byte};
              phase_next           = PH_TYPE;
            end
            PH_TYPE: begin
              mem_kind_next = mtype;
              if (cur_cmd == CMD_BLOCK_LOAD) begin
                if (bytes_remaining == '0) begin
                  // zero-length load: commit (flash) and acknowledge at once
                  if (mtype == MEM_FLASH) begin
                    results.item[0] = mk_result(K_COMMIT, '0, page24);
                    results.item[1] = mk_result(K_TX, RSP_CR, '0);
                    results.count   = CNT_W'(2);
                    aop             = AOP_INC_PAGE;
                  end else begin
                    results.item[0] = mk_result(K_TX, RSP_CR, '0);
                    results.count   = CNT_W'(1);
                  end
                  phase_next = PH_IDLE;
                end else begin
                  phase_next = PH_LOAD;
                end
              end else if (bytes_remaining == '0 || mtype == MEM_UNKNOWN) begin
                phase_next = PH_IDLE;
              end else begin
                results.item[0] = mk_result((mtype == MEM_FLASH) ? K_FLRD : K_EERD, '0, addr24);
                results.count   = CNT_W'(1);
                aop             = AOP_INC1;
                phase_next      = PH_READ_WAIT;
              end
            end
            PH_LOAD: begin
              if (mem_kind == MEM_FLASH && idx < PAGE16) begin
                results.item[0] = mk_result(K_FILL, in_byte, 24'(idx));
                p               = CNT_W'(1);
              end else if (mem_kind == MEM_EEPROM) begin
                results.item[0] = mk_result(K_EEWR, in_byte, addr24);
                p               = CNT_W'(1);
                aop             = AOP_INC1;
              end
              bytes_remaining_next = rem_dec;
              if (rem_dec == '0) begin
                if (mem_kind == MEM_FLASH) begin
                  results.item[p]            = mk_result(K_COMMIT, '0, page24);
                  results.item[p+CNT_W'(1)]  = mk_result(K_TX, RSP_CR, '0);
                  results.count              = p + CNT_W'(2);
                  aop                        = AOP_INC_PAGE;
                end else begin
                  results.item[p] = mk_result(K_TX, RSP_CR, '0);
                  results.count   = p + CNT_W'(1);
                end
                phase_next = PH_IDLE;
              end else begin
                results.count = p;
              end
            end
            default: ; // serial byte while waiting for memory data
          endcase
        end
        REQ_MEM_DATA: begin
          if (phase == PH_READ_WAIT) begin
            results.item[0]      = mk_result(K_TX, in_byte, '0);
            bytes_remaining_next = rem_dec;
            if (rem_dec != '0) begin
              results.item[1] = mk_result((mem_kind == MEM_FLASH) ? K_FLRD : K_EERD, '0, addr24);
              results.count   = CNT_W'(2);
              aop             = AOP_INC1;
            end else begin
              results.count = CNT_W'(1);
              phase_next    = PH_IDLE;
            end
          end
        end
        REQ_TIMEOUT: begin
          results.item[0]   = mk_result(K_END, '0, '0);
          results.count     = CNT_W'(1);
          session_over_next = 1'b1;
          phase_next        = PH_IDLE;
        end
        REQ_NONE: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase           <= PH_IDLE;
      cur_cmd         <= '0;
      block_length    <= '0;
      bytes_remaining <= '0;
      mem_kind        <= MEM_UNKNOWN;
      session_over    <= 1'b0;
    end else if (accept) begin
      phase           <= phase_next;
      cur_cmd         <= cur_cmd_next;
      block_length    <= block_length_next;
      bytes_remaining <= bytes_remaining_next;
      mem_kind        <= mem_kind_next;
      session_over    <= session_over_next;
    end
  end

  // Page index and offset track byte_address. A new address from the set
  // address command is split in two steps: reciprocal multiply for the page,
  // then a multiply back for the offset. Increments update both directly.
  assign quot_prod = byte_address[15:0] * RECIP;
  assign back_prod = page_index[15:0] * PAGE16;
  assign rem_val   = byte_address[15:0] - back_prod[15:0];
  assign sum_pg    = {1'b0, byte_address} + (ADDR_BITS+1)'(PAGE_BYTES);
  assign off_inc   = {1'b0, page_offset} + (OFF_W+1)'(1);

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_address <= '0;
      page_index   <= '0;
      page_offset  <= '0;
      fix_q        <= 1'b0;
      fix_r        <= 1'b0;
    end else if (fix_q) begin
      page_index <= ADDR_BITS'(quot_prod[47:32]);
      fix_q      <= 1'b0;
      fix_r      <= 1'b1;
    end else if (fix_r) begin
      page_offset <= OFF_W'(rem_val);
      fix_r       <= 1'b0;
    end else if (accept) begin
      unique case (aop)
        AOP_NONE: ;
        AOP_SET_HI: byte_address <= ADDR_BITS'({in_byte, 8'h00});
        AOP_SET_LO: begin
          byte_address <= byte_address | ADDR_BITS'(in_byte);
          fix_q        <= 1'b1;
        end
        AOP_INC1: begin
          if (&byte_address) begin
            byte_address <= '0;
            page_index   <= '0;
            page_offset  <= '0;
          end else begin
            byte_address <= byte_address + ADDR_BITS'(1);
            if (off_inc == (OFF_W+1)'(PAGE_BYTES)) begin
              page_offset <= '0;
              page_index  <= page_index + ADDR_BITS'(1);
            end else begin
              page_offset <= off_inc[OFF_W-1:0];
            end
          end
        end
        AOP_INC_PAGE: begin
          byte_address <= sum_pg[ADDR_BITS-1:0];
          if (sum_pg[ADDR_BITS]) begin
            // wrapped: new address is below one page
            page_index  <= '0;
            page_offset <= OFF_W'(sum_pg[ADDR_BITS-1:0]);
          end else begin
            page_index <= page_index + ADDR_BITS'(1);
          end
        end
        default: ;
      endcase
    end
  end

endmodule

@@ rtl/avr109_bootloader_command_parser.sv @@
// AVR109-style loader command parser.
// Request channel (req_valid/req_ready): req_type selects a received serial
// byte, a memory read data byte or a link timeout; in_byte carries the byte.
// Response channel (rsp_valid/rsp_ready): one transaction per result, with
// out_kind (transmit, flash fill, page commit, eeprom write, flash/eeprom read,
// erase, session end), out_byte, out_addr, and last on the final result of a
// request. Config channel (cfg_valid/cfg_ready) writes software ID text and
// version bytes; it is always ready and meant for use while the block is idle.
// Latency: results of a request appear the cycle after it is accepted.
// A request with no result leaves the response stage free; one with N results
// holds the response stage until the last of them leaves, and the next request
// is taken in the cycle the last result leaves. A set address command blocks
// requests while the page index and then the offset of the new address are
// computed by multiplication. A stalled receiver holds the current result and
// blocks new requests until the final result of the previous request is taken.
// Reset clears the parse state, address, counts and config registers.
// After a session end every request is accepted and dropped until reset.
module avr109_bootloader_command_parser #(
  parameter int PAGE_BYTES = 256,
  parameter int ADDR_BITS  = 24
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        req_valid,
  output logic        req_ready,
  input  logic [1:0]  req_type,
  input  logic [7:0]  in_byte,
  output logic        rsp_valid,
  input  logic        rsp_ready,
  output logic [2:0]  out_kind,
  output logic [7:0]  out_byte,
  output logic [23:0] out_addr,
  output logic        last,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [55:0] cfg_data
);
  import avr109_pkg::*;

  logic [55:0] sw_id;
  logic [7:0]  ver_major;
  logic [7:0]  ver_minor;
  logic        accept;
  logic        busy;
  logic        q_free;
  logic        q_load;
  res_list_t   results;
  result_t     head;

  assign cfg_ready = 1'b1;
  assign req_ready = !busy && q_free;
  assign accept    = req_valid && req_ready;
  assign q_load    = accept && (results.count != '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      sw_id     <= '0;
      ver_major <= '0;
      ver_minor <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_SW_ID:     sw_id     <= cfg_data;
        CFG_VER_MAJOR: ver_major <= cfg_data[7:0];
        CFG_VER_MINOR: ver_minor <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  avr109_cmd_decode #(
    .PAGE_BYTES(PAGE_BYTES),
    .ADDR_BITS (ADDR_BITS)
  ) u_decode (
    .clk      (clk),
    .rst      (rst),
    .accept   (accept),
    .req_type (req_type),
    .in_byte  (in_byte),
    .sw_id    (sw_id),
    .ver_major(ver_major),
    .ver_minor(ver_minor),
    .results  (results),
    .busy     (busy)
  );

  avr109_result_queue u_queue (
    .clk  (clk),
    .rst  (rst),
    .load (q_load),
    .list (results),
    .take (rsp_ready),
    .head (head),
    .valid(rsp_valid),
    .last (last),
    .free (q_free)
  );

  assign out_kind = head.kind;
  assign out_byte = head.data;
  assign out_addr = head.addr;

`ifndef SYNTHESIS
  a_stall_blocks_req: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && !rsp_ready) |-> !req_ready)
    else $error("request taken while a result is stalled");

  a_ready_only_on_last: assert property (@(posedge clk) disable iff (rst)
    (req_ready && rsp_valid) |-> last)
    else $error("request taken with more than one result pending");

  a_end_is_last: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && out_kind == K_END) |-> last)
    else $error("session end is not the final result");

  a_last_then_empty: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && rsp_ready && last && !(req_valid && req_ready)) |=> !rsp_valid)
    else $error("result appeared without a request");
`endif

endmodule

@@ test/avr109_bootloader_command_parser_tb.sv @@
`timescale 1ns / 1ps

module avr109_bootloader_command_parser_tb;
  import avr109_pkg::*;

  localparam int PAGE_BYTES   = 256;
  localparam int QUIET_CYCLES = 16;

  typedef struct packed {
    kind_t       kind;
    logic [7:0]  data;
    logic [23:0] addr;
    logic        last;
  } reply_t;

  logic        clk;
  logic        rst;
  logic        req_valid;
  logic        req_ready;
  logic [1:0]  req_type;
  logic [7:0]  in_byte;
  logic        rsp_valid;
  logic        rsp_ready;
  logic [2:0]  out_kind;
  logic [7:0]  out_byte;
  logic [23:0] out_addr;
  logic        last;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [1:0]  cfg_index;
  logic [55:0] cfg_data;

  // parser state as predicted
  phase_t      prs_phase;
  logic [7:0]  prs_cmd;
  logic [23:0] prs_addr;
  logic [15:0] prs_len;
  logic [15:0] prs_left;
  mem_t        prs_mem;
  bit          prs_done;
  logic [55:0] id_text_q;
  logic [7:0]  ver_major_q;
  logic [7:0]  ver_minor_q;

  reply_t      pending_replies[$];
  reply_t      want;
  int unsigned bad_replies = 0;
  int unsigned useful_items = 0;
  int unsigned send_idle_pct = 0;
  int unsigned recv_stall_pct = 0;

  avr109_bootloader_command_parser #(
    .PAGE_BYTES(PAGE_BYTES),
    .ADDR_BITS (24)
  ) DUT (
    .clk      (clk),
    .rst      (rst),
    .req_valid(req_valid),
    .req_ready(req_ready),
    .req_type (req_type),
    .in_byte  (in_byte),
    .rsp_valid(rsp_valid),
    .rsp_ready(rsp_ready),
    .out_kind (out_kind),
    .out_byte (out_byte),
    .out_addr (out_addr),
    .last     (last),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #5_000_000;
    $display("CHECKS FAILED");
    $finish;
  end

  initial begin
    rsp_ready <= 1'b0;
    forever begin
      @(posedge clk);
      rsp_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end
  end

  // ---------------------------------------------------------------- predictor

  function automatic void queue_reply(kind_t k, logic [7:0] d, logic [23:0] a);
    reply_t r;
    r.kind = k;
    r.data = d;
    r.addr = a;
    r.last = 1'b0;
    pending_replies.push_back(r);
  endfunction

  function automatic void close_block_load();
    if (prs_mem == MEM_FLASH) begin
      queue_reply(K_COMMIT, 8'h00, 24'(prs_addr / PAGE_BYTES));
      prs_addr = prs_addr + 24'(PAGE_BYTES);
    end
    queue_reply(K_TX, RSP_CR, 24'h0);
    prs_phase = PH_IDLE;
  endfunction

  function automatic void request_read();
    queue_reply((prs_mem == MEM_FLASH) ? K_FLRD : K_EERD, 8'h00, prs_addr);
    prs_addr = prs_addr + 24'd1;
    prs_phase = PH_READ_WAIT;
  endfunction

  function automatic void decode_command(logic [7:0] c);
    int i;
    prs_cmd = c;
    case (c)
      CMD_ENTER_PROG, CMD_LEAVE_PROG: queue_reply(K_TX, RSP_CR, 24'h0);
      CMD_AUTO_INC:   queue_reply(K_TX, RSP_YES, 24'h0);
      CMD_LOAD_ADDR:  prs_phase = PH_ADDR_HI;
      CMD_ERASE_ALL: begin
        queue_reply(K_ERASE, 8'h00, 24'h0);
        queue_reply(K_TX, RSP_CR, 24'h0);
      end
      CMD_SEL_DEVICE: prs_phase = PH_DEVTYPE;
      CMD_SIGNATURE: begin
        queue_reply(K_TX, SIG_BYTE0, 24'h0);
        queue_reply(K_TX, SIG_BYTE1, 24'h0);
        queue_reply(K_TX, SIG_BYTE2, 24'h0);
      end
      CMD_DEV_CODES:  queue_reply(K_TX, RSP_DEV_CODE, 24'h0);
      CMD_SW_ID: begin
        for (i = 6; i >= 0; i--) queue_reply(K_TX, id_text_q[8*i +: 8], 24'h0);
      end
      CMD_SW_VERSION: begin
        queue_reply(K_TX, ver_major_q, 24'h0);
        queue_reply(K_TX, ver_minor_q, 24'h0);
      end
      CMD_HW_VERSION: begin
        queue_reply(K_TX, RSP_HW_MAJOR, 24'h0);
        queue_reply(K_TX, RSP_HW_MINOR, 24'h0);
      end
      CMD_PROG_TYPE:  queue_reply(K_TX, RSP_SERIAL_PROG, 24'h0);
      CMD_BLOCK_SUPP: begin
        queue_reply(K_TX, RSP_YES, 24'h0);
        queue_reply(K_TX, 8'((PAGE_BYTES >> 8) & 8'hFF), 24'h0);
        queue_reply(K_TX, 8'(PAGE_BYTES & 8'hFF), 24'h0);
      end
      CMD_EXIT: begin
        queue_reply(K_TX, RSP_CR, 24'h0);
        queue_reply(K_END, 8'h00, 24'h0);
        prs_done = 1'b1;
      end
      CMD_BLOCK_LOAD, CMD_BLOCK_READ: prs_phase = PH_LEN_HI;
      default: queue_reply(K_TX, RSP_UNKNOWN, 24'h0);
    endcase
  endfunction

  function automatic void take_serial(logic [7:0] b);
    logic [15:0] offset;
    case (prs_phase)
      PH_IDLE: decode_command(b);
      PH_ADDR_HI: begin
        prs_addr = {8'h00, b, 8'h00};
        prs_phase = PH_ADDR_LO;
      end
      PH_ADDR_LO: begin
        prs_addr[7:0] = b;
        queue_reply(K_TX, RSP_CR, 24'h0);
        prs_phase = PH_IDLE;
      end
      PH_DEVTYPE: begin
        queue_reply(K_TX, RSP_CR, 24'h0);
        prs_phase = PH_IDLE;
      end
      PH_LEN_HI: begin
        prs_len = {b, 8'h00};
        prs_phase = PH_LEN_LO;
      end
      PH_LEN_LO: begin
        prs_len[7:0] = b;
        prs_left = {prs_len[15:8], b};
        prs_phase = PH_TYPE;
      end
      PH_TYPE: begin
        prs_mem = (b == TYPE_FLASH) ? MEM_FLASH : (b == TYPE_EEPROM) ? MEM_EEPROM : MEM_UNKNOWN;
        if (prs_cmd == CMD_BLOCK_LOAD) begin
          if (prs_left == 16'd0) close_block_load();
          else prs_phase = PH_LOAD;
        end else if (prs_left == 16'd0 || prs_mem == MEM_UNKNOWN) begin
          prs_phase = PH_IDLE;
        end else begin
          request_read();
        end
      end
      PH_LOAD: begin
        offset = prs_len - prs_left;
        if (prs_mem == MEM_FLASH) begin
          // bytes past the page are dropped
          if (offset < PAGE_BYTES) queue_reply(K_FILL, b, {8'h00, offset});
        end else if (prs_mem == MEM_EEPROM) begin
          queue_reply(K_EEWR, b, prs_addr);
          prs_addr = prs_addr + 24'd1;
        end
        prs_left = prs_left - 16'd1;
        if (prs_left == 16'd0) close_block_load();
      end
      default: ;
    endcase
  endfunction

  // returns 1 when the request is not simply dropped
  function automatic bit parse_request(req_t t, logic [7:0] b);
    int unsigned n0;
    bit used;
    n0 = pending_replies.size();
    used = 1'b0;
    if (!prs_done) begin
      case (t)
        REQ_SERIAL: begin
          used = (prs_phase != PH_READ_WAIT);
          take_serial(b);
        end
        REQ_MEM_DATA: begin
          if (prs_phase == PH_READ_WAIT) begin
            used = 1'b1;
            queue_reply(K_TX, b, 24'h0);
            prs_left = prs_left - 16'd1;
            if (prs_left != 16'd0) request_read();
            else prs_phase = PH_IDLE;
          end
        end
        REQ_TIMEOUT: begin
          used = 1'b1;
          queue_reply(K_END, 8'h00, 24'h0);
          prs_done = 1'b1;
          prs_phase = PH_IDLE;
        end
        default: ;
      endcase
    end
    if (pending_replies.size() > n0) pending_replies[pending_replies.size() - 1].last = 1'b1;
    return used;
  endfunction

  // ---------------------------------------------------------------- checker

  always @(posedge clk) begin
    if (!rst && rsp_valid && rsp_ready) begin
      if (pending_replies.size() == 0) begin
        $display("%0t: unexpected result: kind %0d byte %02h addr %06h last %0b",
                 $time, out_kind, out_byte, out_addr, last);
        bad_replies++;
      end else begin
        want = pending_replies.pop_front();
        if (out_kind !== want.kind || out_byte !== want.data || out_addr !== want.addr ||
            last !== want.last) begin
          $display({"%0t: expected kind %0d byte %02h addr %06h last %0b, ",
                    "got kind %0d byte %02h addr %06h last %0b"},
                   $time, want.kind, want.data, want.addr, want.last,
                   out_kind, out_byte, out_addr, last);
          bad_replies++;
        end
      end
    end
  end

  // ---------------------------------------------------------------- drivers

  task automatic send_req(input req_t t, input logic [7:0] b);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      req_valid <= 1'b0;
      @(posedge clk);
    end
    req_valid <= 1'b1;
    req_type  <= t;
    in_byte   <= b;
    @(posedge clk);
    while (!req_ready) @(posedge clk);
    if (parse_request(t, b)) useful_items++;
  endtask

  // keeps random traffic from ending the session
  task automatic send_serial(input logic [7:0] b);
    logic [7:0] v;
    v = b;
    if (prs_phase == PH_IDLE && v == CMD_EXIT) v = CMD_PROG_TYPE;
    send_req(REQ_SERIAL, v);
  endtask

  task automatic send_noise();
    case ($urandom_range(0, 2))
      0: send_serial(8'($urandom_range(0, 255)));
      1: send_req(REQ_MEM_DATA, 8'($urandom_range(0, 255)));
      default: send_req(REQ_NONE, 8'($urandom_range(0, 255)));
    endcase
  endtask

  task automatic drain_results();
    req_valid <= 1'b0;
    while (pending_replies.size() != 0) @(posedge clk);
    repeat (QUIET_CYCLES) @(posedge clk);
  endtask

  task automatic apply_settings(input logic [55:0] id_text, input logic [7:0] ver_hi,
                                input logic [7:0] ver_lo);
    int i;
    cfg_idx_t idx;
    for (i = 0; i < 3; i++) begin
      idx = cfg_idx_t'(i);
      cfg_valid <= 1'b1;
      cfg_index <= idx;
      case (idx)
        CFG_SW_ID:     cfg_data <= id_text;
        CFG_VER_MAJOR: cfg_data <= {16'($urandom), 32'($urandom), ver_hi};
        default:       cfg_data <= {16'($urandom), 32'($urandom), ver_lo};
      endcase
      @(posedge clk);
      while (!cfg_ready) @(posedge clk);
    end
    cfg_valid <= 1'b0;
    id_text_q   = id_text;
    ver_major_q = ver_hi;
    ver_minor_q = ver_lo;
  endtask

  // walk any half-parsed command back to idle with short lengths
  task automatic settle_parser();
    while (prs_phase != PH_IDLE) begin
      case (prs_phase)
        PH_READ_WAIT: send_req(REQ_MEM_DATA, 8'($urandom_range(0, 255)));
        PH_LEN_HI:    send_serial(8'h00);
        PH_LEN_LO:    send_serial(8'($urandom_range(0, 15)));
        default:      send_serial(8'($urandom_range(0, 255)));
      endcase
    end
  endtask

  function automatic logic [7:0] pick_block_type();
    case ($urandom_range(0, 9))
      0, 1, 2, 3: return TYPE_FLASH;
      4, 5, 6, 7: return TYPE_EEPROM;
      default:    return 8'($urandom_range(0, 255));
    endcase
  endfunction

  task automatic random_sequence();
    int unsigned pick;
    logic [7:0] cmd;
    logic [7:0] blk_type;
    logic [15:0] len;
    pick = $urandom_range(0, 99);
    if (pick < 12) begin
      send_noise();
      return;
    end
    settle_parser();
    if (pick < 45) begin
      case ($urandom_range(0, 13))
        0:  cmd = CMD_ENTER_PROG;
        1:  cmd = CMD_LEAVE_PROG;
        2:  cmd = CMD_AUTO_INC;
        3:  cmd = CMD_ERASE_ALL;
        4:  cmd = CMD_SEL_DEVICE;
        5:  cmd = CMD_SIGNATURE;
        6:  cmd = CMD_DEV_CODES;
        7:  cmd = CMD_SW_ID;
        8:  cmd = CMD_SW_VERSION;
        9:  cmd = CMD_HW_VERSION;
        10: cmd = CMD_PROG_TYPE;
        11: cmd = CMD_BLOCK_SUPP;
        default: cmd = 8'($urandom_range(0, 255));
      endcase
      send_serial(cmd);
      if (cmd == CMD_SEL_DEVICE) send_serial(8'($urandom_range(0, 255)));
    end else if (pick < 55) begin
      send_serial(CMD_LOAD_ADDR);
      send_serial(8'($urandom_range(0, 255)));
      send_serial(8'($urandom_range(0, 255)));
    end else if (pick < 80) begin
      len = ($urandom_range(0, 9) == 0) ? 16'($urandom_range(0, 40)) : 16'($urandom_range(0, 8));
      send_serial(CMD_BLOCK_LOAD);
      send_serial(len[15:8]);
      send_serial(len[7:0]);
      send_serial(pick_block_type());
      while (prs_phase == PH_LOAD) begin
        if ($urandom_range(0, 9) == 0) send_noise();
        else send_serial(8'($urandom_range(0, 255)));
      end
    end else begin
      blk_type = pick_block_type();
      len = 16'($urandom_range(0, 6));
      // unknown type reads nothing, so any length is cheap
      if (blk_type != TYPE_FLASH && blk_type != TYPE_EEPROM && $urandom_range(0, 1) == 1)
        len = 16'($urandom_range(0, 65535));
      send_serial(CMD_BLOCK_READ);
      send_serial(len[15:8]);
      send_serial(len[7:0]);
      send_serial(blk_type);
      while (prs_phase == PH_READ_WAIT) begin
        if ($urandom_range(0, 5) == 0) send_noise();
        else send_req(REQ_MEM_DATA, 8'($urandom_range(0, 255)));
      end
    end
  endtask

  task automatic random_phase(input int unsigned send_pct, input int unsigned recv_pct,
                              input int unsigned target);
    int unsigned start;
    send_idle_pct  = send_pct;
    recv_stall_pct = recv_pct;
    start = useful_items;
    send_serial(CMD_SW_ID);
    send_serial(CMD_SW_VERSION);
    while (useful_items - start < target) random_sequence();
    drain_results();
  endtask

  // ---------------------------------------------------------------- tests

  task automatic test_single_commands();
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    send_serial(CMD_ENTER_PROG);
    send_serial(CMD_LEAVE_PROG);
    send_serial(CMD_AUTO_INC);
    send_serial(CMD_ERASE_ALL);
    send_serial(CMD_SEL_DEVICE);
    send_serial(8'hFF);
    send_serial(CMD_SIGNATURE);
    send_serial(CMD_DEV_CODES);
    send_serial(CMD_SW_ID);
    send_serial(CMD_SW_VERSION);
    send_serial(CMD_HW_VERSION);
    send_serial(CMD_PROG_TYPE);
    send_serial(CMD_BLOCK_SUPP);
    send_serial(8'hFF);
    drain_results();
  endtask

  task automatic test_block_corners();
    // empty flash load commits right away
    send_serial(CMD_BLOCK_LOAD);
    send_serial(8'h00);
    send_serial(8'h00);
    send_serial(TYPE_FLASH);
    // read of unknown type goes straight back to idle
    send_serial(CMD_BLOCK_READ);
    send_serial(8'hFF);
    send_serial(8'hFF);
    send_serial(8'h00);
    send_req(REQ_MEM_DATA, 8'hA5);
    send_req(REQ_NONE, 8'h5A);
    drain_results();
  endtask

  task automatic test_page_overflow();
    int i;
    recv_stall_pct = 28;
    send_serial(CMD_LOAD_ADDR);
    send_serial(8'h12);
    send_serial(8'h34);
    send_serial(CMD_BLOCK_LOAD);
    send_serial(8'h01);
    send_serial(8'h02);
    send_serial(TYPE_FLASH);
    for (i = 0; i < 258; i++) send_serial(8'($urandom_range(0, 255)));
    drain_results();
  endtask

  task automatic test_random_traffic();
    apply_settings({56{1'b1}}, 8'hFF, 8'h00);
    random_phase(0, 0, 14);
    apply_settings({24'($urandom), 32'($urandom)}, 8'($urandom), 8'($urandom));
    random_phase(88, 0, 14);
    apply_settings(56'h0, 8'h00, 8'hFF);
    random_phase(0, 88, 14);
    apply_settings({24'($urandom), 32'($urandom)}, 8'($urandom), 8'($urandom));
    random_phase(28, 28, 14);
  endtask

  task automatic test_session_end();
    send_idle_pct  = 28;
    recv_stall_pct = 28;
    settle_parser();
    if ($urandom_range(0, 1) == 1) begin
      send_req(REQ_SERIAL, CMD_EXIT);
      send_req(REQ_TIMEOUT, 8'h00);
    end else begin
      // timeout in the middle of a block load
      send_serial(CMD_BLOCK_LOAD);
      send_serial(8'h00);
      send_serial(8'h05);
      send_serial(TYPE_FLASH);
      send_serial(8'($urandom_range(0, 255)));
      send_req(REQ_TIMEOUT, 8'($urandom_range(0, 255)));
      send_req(REQ_SERIAL, CMD_EXIT);
    end
    // everything after the session end is dropped
    send_req(REQ_SERIAL, CMD_ENTER_PROG);
    send_req(REQ_MEM_DATA, 8'h3C);
    send_req(REQ_TIMEOUT, 8'h00);
    drain_results();
  endtask

  initial begin
    rst       <= 1'b1;
    req_valid <= 1'b0;
    req_type  <= REQ_NONE;
    in_byte   <= 8'h00;
    cfg_valid <= 1'b0;
    cfg_index <= CFG_SW_ID;
    cfg_data  <= 56'h0;
    prs_phase   = PH_IDLE;
    prs_cmd     = 8'h00;
    prs_addr    = 24'h0;
    prs_len     = 16'h0;
    prs_left    = 16'h0;
    prs_mem     = MEM_UNKNOWN;
    prs_done    = 1'b0;
    id_text_q   = 56'h0;
    ver_major_q = 8'h00;
    ver_minor_q = 8'h00;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_single_commands();
    test_block_corners();
    test_page_overflow();
    test_random_traffic();
    test_session_end();

    if (bad_replies == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
